[src/pft_pkg.sv]
`timescale 1ns / 1ps
// pft_pkg: shared types and constants for the page frame table.
// Used by pft_cell and lru_page_frame_table; depends on nothing.
package pft_pkg;

    localparam int FAULT_W = 16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEL    = 4'b0010,
        S_GATHER = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    // "Seen so far" flags rippled from frame 0 upwards
    typedef struct packed {
        logic match;
        logic free;
        logic oldest;
    } flag_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic pick;     // latch this cell's select bit
        logic upd;      // commit install and recency update
        logic is_hit;   // request matched a resident page
        logic is_free;  // an empty frame exists
    } ctl_t;

endpackage

[src/pft_cell.sv]
`timescale 1ns / 1ps
// pft_cell: one page frame (page, valid, recency rank) of the table.
// Depends on pft_pkg; chained frame 0 upwards in lru_page_frame_table.
module pft_cell
    import pft_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 8,
    parameter int IDX       = 0
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctl_t                         ctl,
    input  logic [PAGE_BITS-1:0]         req_page,
    input  logic [$clog2(FRAMES):0]      old_rank,
    input  flag_t                        flag_in,
    output flag_t                        flag_out,
    input  logic [$clog2(FRAMES):0]      rank_in,
    output logic [$clog2(FRAMES):0]      rank_out,
    input  logic [PAGE_BITS-1:0]         page_in,
    output logic [PAGE_BITS-1:0]         page_out,
    input  logic [$clog2(FRAMES)-1:0]    idx_in,
    output logic [$clog2(FRAMES)-1:0]    idx_out,
    output logic                         valid,
    output logic                         sel
);

    localparam int IDX_W = $clog2(FRAMES);
    localparam logic [IDX_W-1:0] AGE_MAX = IDX_W'(FRAMES - 1);
    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic                 valid_next;
    logic [IDX_W-1:0]     age_reg;
    logic [IDX_W-1:0]     age_next;
    logic                 sel_reg;
    logic                 sel_next;
    logic                 my_match;
    logic                 my_free;
    logic                 my_oldest;

    // local compare
    assign my_match  = valid_reg && (page_reg == req_page);
    assign my_free   = !valid_reg;
    assign my_oldest = valid_reg && (age_reg == AGE_MAX);

    assign flag_out.match  = flag_in.match  | my_match;
    assign flag_out.free   = flag_in.free   | my_free;
    assign flag_out.oldest = flag_in.oldest | my_oldest;

    // first claimant in the chain wins
    always_comb
    begin
        if (ctl.is_hit)
            sel_next = my_match && !flag_in.match;
        else if (ctl.is_free)
            sel_next = my_free && !flag_in.free;
        else
            sel_next = my_oldest && !flag_in.oldest;
    end

    // gather chain: selected cell ORs in its rank, page and index
    assign rank_out = rank_in | (sel_reg ? {1'b0, age_reg} : '0);
    assign page_out = page_in | ((sel_reg && valid_reg) ? page_reg : '0);
    assign idx_out  = idx_in  | (sel_reg ? MY_IDX : '0);

    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        if (ctl.upd)
        begin
            if (sel_reg)
            begin
                valid_next = 1'b1;
                age_next   = '0;
            end
            else if (valid_reg && ({1'b0, age_reg} < old_rank) && (age_reg != AGE_MAX))
            begin
                age_next = age_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            if (ctl.pick)
                sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.upd && sel_reg)
            page_reg <= req_page;
    end

    assign valid = valid_reg;
    assign sel   = sel_reg;

endmodule

[src/lru_page_frame_table.sv]
`timescale 1ns / 1ps
// lru_page_frame_table: fully associative page frame table, LRU replacement.
// A request word is taken in IDLE, then passes through the select, gather and
// update passes over the frame chain; update loads the result word. No new request
// word is taken until update is done. Output register holds a result while stalled.
// Reset (async, rst_n low): all frames empty, ranks and fault count zero.
// Depends on pft_pkg and pft_cell.
module lru_page_frame_table
    import pft_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [PAGE_BITS-1:0]       page_number,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic [$clog2(FRAMES)-1:0]  frame_index,
    output logic                       evicted_valid,
    output logic [PAGE_BITS-1:0]       evicted_page,
    output logic [FAULT_W-1:0]         fault_count
);

    localparam int IDX_W = $clog2(FRAMES);

    // Sequencer
    //   IDLE   : take a request word
    //   SEL    : every cell compares; flag chain picks hit / free / oldest frame
    //   GATHER : selected cell drives its rank, page and index down the chain
    //   UPDATE : install page, age younger frames, load the output register
    state_t state_reg;
    state_t state_next;

    logic [PAGE_BITS-1:0] req_page_reg;
    logic                 hit_reg;
    logic                 free_reg;
    logic [IDX_W:0]       old_rank_reg;
    logic [PAGE_BITS-1:0] ev_page_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [FAULT_W-1:0]   faults_reg;
    logic [FAULT_W-1:0]   faults_next;

    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic                 out_ev_valid_reg;
    logic [PAGE_BITS-1:0] out_ev_page_reg;
    logic [FAULT_W-1:0]   out_faults_reg;

    logic                 out_free;
    logic                 in_take;
    ctl_t                 ctl;

    // Chains between cells; element 0 is the head
    flag_t                flag_chain [FRAMES+1];
    logic [IDX_W:0]       rank_chain [FRAMES+1];
    logic [PAGE_BITS-1:0] page_chain [FRAMES+1];
    logic [IDX_W-1:0]     idx_chain  [FRAMES+1];
    logic [FRAMES-1:0]    valid_vec;
    logic [FRAMES-1:0]    sel_vec;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // The mode always comes straight off the chain tail; cells only latch a pick in SEL
    always_comb
    begin
        ctl.pick    = (state_reg == S_SEL);
        ctl.upd     = (state_reg == S_UPDATE) && out_free;
        ctl.is_hit  = flag_chain[FRAMES].match;
        ctl.is_free = flag_chain[FRAMES].free;
    end

    assign flag_chain[0] = '0;
    assign rank_chain[0] = '0;
    assign page_chain[0] = '0;
    assign idx_chain[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++)
        begin : g_cell
            pft_cell #(
                .FRAMES    (FRAMES),
                .PAGE_BITS (PAGE_BITS),
                .IDX       (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .req_page (req_page_reg),
                .old_rank (old_rank_reg),
                .flag_in  (flag_chain[g]),
                .flag_out (flag_chain[g+1]),
                .rank_in  (rank_chain[g]),
                .rank_out (rank_chain[g+1]),
                .page_in  (page_chain[g]),
                .page_out (page_chain[g+1]),
                .idx_in   (idx_chain[g]),
                .idx_out  (idx_chain[g+1]),
                .valid    (valid_vec[g]),
                .sel      (sel_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_take) state_next = S_SEL;
            S_SEL:    state_next = S_GATHER;
            S_GATHER: state_next = S_UPDATE;
            S_UPDATE: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // saturating fault counter
    assign faults_next = (!hit_reg && (faults_reg != FAULT_MAX)) ? faults_reg + 1'b1
                                                                 : faults_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SEL)
            begin
                hit_reg  <= ctl.is_hit;
                free_reg <= !ctl.is_hit && ctl.is_free;
            end
            if (ctl.upd)
                faults_reg <= faults_next;
            if (ctl.upd)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            req_page_reg <= page_number;
        if (state_reg == S_GATHER)
        begin
            // a fill ages every valid frame: old rank is FRAMES
            old_rank_reg <= free_reg ? (IDX_W+1)'(FRAMES) : rank_chain[FRAMES];
            ev_page_reg  <= (hit_reg || free_reg) ? '0 : page_chain[FRAMES];
            idx_reg      <= idx_chain[FRAMES];
        end
        if (ctl.upd)
        begin
            out_hit_reg      <= hit_reg;
            out_idx_reg      <= idx_reg;
            out_ev_valid_reg <= !hit_reg && !free_reg;
            out_ev_page_reg  <= ev_page_reg;
            out_faults_reg   <= faults_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign frame_index   = out_idx_reg;
    assign evicted_valid = out_ev_valid_reg;
    assign evicted_page  = out_ev_page_reg;
    assign fault_count   = out_faults_reg;

    // exactly one frame is chosen for every request
    a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATHER) |-> $onehot(sel_vec))
        else $error("frame select not one-hot");

    // frames never become empty again
    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(valid_vec) >= $past($countones(valid_vec))))
        else $error("resident frame count dropped");

    // an eviction only happens with every frame resident
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.upd && !hit_reg && !free_reg) |-> (valid_vec == {FRAMES{1'b1}}))
        else $error("eviction with an empty frame present");

    // a new result is loaded only from the update pass
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_UPDATE))
        else $error("result word appeared outside update");

endmodule

[dv/lru_page_frame_table_tb.sv]
`timescale 1ns / 1ps
// lru_page_frame_table_tb: self-checking bench for the LRU page frame table.
// Drives request words with bursts and gaps, stalls the result side and checks
// every result word against a built-in frame table predictor. Needs pft_pkg.
module lru_page_frame_table_tb;
    import pft_pkg::*;

    localparam int FRAMES       = 8;
    localparam int PAGE_BITS    = 8;
    localparam int FRAME_W      = $clog2(FRAMES);
    localparam int RANDOM_WORDS = 680;     // plus the directed words, about 700 in all
    localparam int IDLE_LIMIT   = 4000;    // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES = 8;       // result latency plus margin

    // One result word as the block presents it
    typedef struct packed {
        logic                 hit;
        logic [FRAME_W-1:0]   frame;
        logic                 evicted;
        logic [PAGE_BITS-1:0] victim_page;
        logic [FAULT_W-1:0]   faults;
    } page_result_t;

    // Frame table predictor plus the queue of results still owed by the block
    class frame_table_scoreboard;
        logic [PAGE_BITS-1:0] held_page[FRAMES];
        bit                   resident[FRAMES];
        int unsigned          rank[FRAMES];
        logic [FAULT_W-1:0]   fault_total;
        page_result_t         expected_lookups[$];
        int unsigned          mismatches;

        function new();
            foreach (resident[i])
            begin
                resident[i]  = 1'b0;
                rank[i]      = 0;
                held_page[i] = '0;
            end
            fault_total = '0;
            mismatches  = 0;
        endfunction

        // Frame f becomes most recent; valid frames younger than its old rank age by one
        function void promote(int f, int unsigned old_rank);
            for (int i = 0; i < FRAMES; i++)
                if (i != f && resident[i] && rank[i] < old_rank && rank[i] < FRAMES - 1)
                    rank[i]++;
            rank[f] = 0;
        endfunction

        function page_result_t resolve_page(logic [PAGE_BITS-1:0] page);
            page_result_t r;
            int           f;
            int unsigned  oldest;
            r = '0;
            f = -1;
            for (int i = 0; i < FRAMES; i++)
                if (f < 0 && resident[i] && held_page[i] == page)
                    f = i;
            if (f >= 0)
            begin
                r.hit = 1'b1;
                promote(f, rank[f]);
            end
            else
            begin
                if (fault_total != FAULT_MAX)
                    fault_total++;
                for (int i = 0; i < FRAMES; i++)
                    if (f < 0 && !resident[i])
                        f = i;
                if (f >= 0)
                begin
                    // empty frame: fill it, everything resident ages
                    resident[f]  = 1'b1;
                    held_page[f] = page;
                    promote(f, FRAMES);
                end
                else
                begin
                    // table full: oldest rank goes, lowest index on a tie
                    f      = 0;
                    oldest = 0;
                    for (int i = 0; i < FRAMES; i++)
                        if (rank[i] > oldest)
                        begin
                            oldest = rank[i];
                            f      = i;
                        end
                    r.evicted     = 1'b1;
                    r.victim_page = held_page[f];
                    held_page[f]  = page;
                    promote(f, rank[f]);
                end
            end
            r.frame  = f[FRAME_W-1:0];
            r.faults = fault_total;
            return r;
        endfunction

        function void note_request(logic [PAGE_BITS-1:0] page);
            expected_lookups.push_back(resolve_page(page));
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(page_result_t got);
            page_result_t want;
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: result word with none outstanding, hit %0d frame %0d",
                         $time, got.hit, got.frame);
                mismatches++;
                return;
            end
            want = expected_lookups.pop_front();
            compare("hit", 32'(want.hit), 32'(got.hit));
            compare("frame_index", 32'(want.frame), 32'(got.frame));
            compare("evicted_valid", 32'(want.evicted), 32'(got.evicted));
            compare("evicted_page", 32'(want.victim_page), 32'(got.victim_page));
            compare("fault_count", 32'(want.faults), 32'(got.faults));
        endfunction

        function int unsigned pending();
            return expected_lookups.size();
        endfunction

        // Some page currently resident, for forcing hits; any page if the table is empty
        function logic [PAGE_BITS-1:0] pick_resident();
            int unsigned start;
            start = $urandom_range(0, FRAMES - 1);
            for (int k = 0; k < FRAMES; k++)
                if (resident[(start + k) % FRAMES])
                    return held_page[(start + k) % FRAMES];
            return PAGE_BITS'($urandom_range(0, 2**PAGE_BITS - 1));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [PAGE_BITS-1:0] page_number = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic                 hit;
    logic [FRAME_W-1:0]   frame_index;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_count;

    frame_table_scoreboard sb = new();

    // receiver stall pattern state
    int unsigned stall_mode  = 0;
    int unsigned phase_left  = 0;
    int unsigned idle_cycles = 0;

    // random page working set: a small window of pages near the frame count
    logic [PAGE_BITS-1:0] pool_base = '0;
    int unsigned          pool_span = 10;

    lru_page_frame_table #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Both handshakes are observed at the rising edge; inputs only move at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(page_number);
            if (out_valid && !out_stall)
                sb.check_result(page_result_t'{hit, frame_index, evicted_valid,
                                               evicted_page, fault_count});
        end
    end

    // Watchdog: a run of cycles with no word moving either way means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: phases of no stall, light stall and heavy stall, each of random length.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (phase_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                phase_left <= $urandom_range(20, 200);
            end
            else
                phase_left <= phase_left - 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Present one request word and hold it until the block takes it.
    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        @(negedge clk);
        in_valid    <= 1'b1;
        page_number <= page;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Hold off until every result word owed has been taken.
    task automatic wait_drained();
        pause_sender(0);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mix: working-set pages (hits and evictions), forced hits, and any page at all.
    function automatic logic [PAGE_BITS-1:0] random_page();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return PAGE_BITS'(pool_base + $urandom_range(0, pool_span));
        else if (pick < 75)
            return sb.pick_resident();
        else
            return PAGE_BITS'($urandom_range(0, 2**PAGE_BITS - 1));
    endfunction

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        int unsigned gap_pick;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: fill the empty frames with extreme and alternating bit patterns,
        // then hits at the oldest, newest and second oldest rank, then LRU evictions.
        send_page(8'h00);
        send_page(8'hFF);
        send_page(8'hAA);
        send_page(8'h55);
        send_page(8'h01);
        send_page(8'h02);
        send_page(8'h03);
        send_page(8'h04);
        send_page(8'h00);   // hit on the oldest frame
        send_page(8'h04);   // hit on the newest: nothing ages
        send_page(8'h04);
        send_page(8'hAA);   // hit on the second oldest frame
        send_page(8'h10);   // table full: misses evict from here on
        send_page(8'h20);
        send_page(8'hFF);
        send_page(8'h55);
        send_page(8'h10);
        send_page(8'h80);
        send_page(8'h7F);
        send_page(8'h01);
        send_page(8'h00);
        send_page(8'hFE);

        // Sender holds off until the table has answered everything so far.
        wait_drained();

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                pool_base = PAGE_BITS'($urandom_range(0, 2**PAGE_BITS - 1));
                pool_span = $urandom_range(3, 14);
            end
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++)
            begin
                send_page(random_page());
                sent++;
            end
            gap_pick = $urandom_range(0, 9);
            if (gap_pick == 0)
                wait_drained();
            else if (gap_pick < 7)
                pause_sender($urandom_range(1, 12));
            // otherwise the next burst follows with no gap
        end

        // Closing words: forced hits on resident pages, then one more lookup.
        wait_drained();
        for (int n = 0; n < 6; n++)
            send_page(sb.pick_resident());
        send_page(8'hC3);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
